### src/fenp_pkg.sv
// Shared types and constants for the chess position string parser.
package fenp_pkg;

   localparam int unsigned HALFMOVE_WIDTH = 10;
   localparam logic [HALFMOVE_WIDTH-1:0] HALFMOVE_MAX = 10'd1023;

   localparam logic [2:0] FIELD_PLACEMENT = 3'd0;
   localparam logic [2:0] FIELD_SIDE      = 3'd1;
   localparam logic [2:0] FIELD_CASTLE    = 3'd2;
   localparam logic [2:0] FIELD_PASSANT   = 3'd3;
   localparam logic [2:0] FIELD_HALFMOVE  = 3'd4;
   localparam logic [2:0] FIELD_LAST      = 3'd7;

   localparam logic [1:0] BM_IDLE  = 2'd0;
   localparam logic [1:0] BM_B     = 2'd1;
   localparam logic [1:0] BM_MATCH = 2'd2;
   localparam logic [1:0] BM_NONE  = 2'd3;

   localparam logic [2:0] PIECE_PAWN   = 3'd0;
   localparam logic [2:0] PIECE_KNIGHT = 3'd1;
   localparam logic [2:0] PIECE_BISHOP = 3'd2;
   localparam logic [2:0] PIECE_ROOK   = 3'd3;
   localparam logic [2:0] PIECE_QUEEN  = 3'd4;
   localparam logic [2:0] PIECE_KING   = 3'd5;

   localparam logic [3:0] BOARD_EDGE = 4'd8;
   localparam logic [2:0] TOKEN_LENGTH_MAX = 3'd7;

   localparam logic RECORD_PIECE   = 1'b0;
   localparam logic RECORD_SUMMARY = 1'b1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_UPPER_K = 8'h4B;
   localparam logic [7:0] CHAR_UPPER_Q = 8'h51;
   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_H = 8'h68;
   localparam logic [7:0] CHAR_K = 8'h6B;
   localparam logic [7:0] CHAR_M = 8'h6D;
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_P = 8'h70;
   localparam logic [7:0] CHAR_Q = 8'h71;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_W = 8'h77;

   typedef struct packed {
      logic [2:0] field_number;
      logic       in_token;
      logic [3:0] rank_row;
      logic [3:0] file_column;
      logic       side_flag;
      logic [3:0] castle_flags;
      logic       passant_flag;
      logic [5:0] passant_index;
      logic [2:0] token_length;
      logic [1:0] bm_match;
      logic [HALFMOVE_WIDTH-1:0] halfmove_accum;
      logic       halfmove_seen;
      logic [7:0] tok_first;
      logic [7:0] tok_second;
      logic       digits_running;
   } fenp_state_type;

   localparam fenp_state_type STATE_RESET = '0;

   typedef struct packed {
      logic       record_kind;
      logic [5:0] square;
      logic       piece_color;
      logic [2:0] piece_kind;
      logic       black_to_move;
      logic [3:0] castle_rights;
      logic       passant_valid;
      logic [5:0] passant_square;
      logic       halfmove_valid;
      logic [HALFMOVE_WIDTH-1:0] halfmove_count;
   } fenp_result_type;

endpackage

### src/fenp_if.sv
// Request and response channel interfaces of the position string parser.
interface fenp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] character;

   modport source (output valid, output command, output character, input ready);
   modport sink (input valid, input command, input character, output ready);
endinterface

interface fenp_rsp_if;
   logic       valid;
   logic       ready;
   logic       record_kind;
   logic [5:0] square;
   logic       piece_color;
   logic [2:0] piece_kind;
   logic       black_to_move;
   logic [3:0] castle_rights;
   logic       passant_valid;
   logic [5:0] passant_square;
   logic       halfmove_valid;
   logic [9:0] halfmove_count;

   modport source (
      output valid, output record_kind, output square, output piece_color,
      output piece_kind, output black_to_move, output castle_rights,
      output passant_valid, output passant_square, output halfmove_valid,
      output halfmove_count, input ready
   );
   modport sink (
      input valid, input record_kind, input square, input piece_color,
      input piece_kind, input black_to_move, input castle_rights,
      input passant_valid, input passant_square, input halfmove_valid,
      input halfmove_count, output ready
   );
endinterface

### src/fen_position_parser.sv
// Chess position string parser: one character per request, piece and summary records out.
// A record is registered; it is valid in the cycle after the request that causes it is accepted.
// One request per cycle unless stalled; the parser state updates in a single pass per character.
// A request is taken while a record waits, as long as that record leaves in the same cycle.
// Reset (synchronous) returns the parser to the placement field and empties the output register.
// An end request emits the summary record and also returns the parser to its reset state.
module fen_position_parser import fenp_pkg::*; (
   input logic        clock,
   input logic        reset,
   fenp_req_if.sink   req_port,
   fenp_rsp_if.source rsp_port
);

   fenp_state_type  state_ff;
   fenp_state_type  state_in;
   fenp_result_type rsp_data_ff;
   fenp_result_type rsp_data_in;
   logic            rsp_valid_ff;
   logic            emit;
   logic            accept;

   fenp_step u_step (
      .state      (state_ff),
      .command    (req_port.command),
      .character  (req_port.character),
      .state_next (state_in),
      .emit       (emit),
      .result     (rsp_data_in)
   );

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.record_kind    = rsp_data_ff.record_kind;
   assign rsp_port.square         = rsp_data_ff.square;
   assign rsp_port.piece_color    = rsp_data_ff.piece_color;
   assign rsp_port.piece_kind     = rsp_data_ff.piece_kind;
   assign rsp_port.black_to_move  = rsp_data_ff.black_to_move;
   assign rsp_port.castle_rights  = rsp_data_ff.castle_rights;
   assign rsp_port.passant_valid  = rsp_data_ff.passant_valid;
   assign rsp_port.passant_square = rsp_data_ff.passant_square;
   assign rsp_port.halfmove_valid = rsp_data_ff.halfmove_valid;
   assign rsp_port.halfmove_count = rsp_data_ff.halfmove_count;

endmodule

### src/fenp_step.sv
// Next-state and result logic for one request of the position string parser.
module fenp_step import fenp_pkg::*; (
   input  fenp_state_type  state,
   input  logic            command,
   input  logic [7:0]      character,
   output fenp_state_type  state_next,
   output logic            emit,
   output fenp_result_type result
);

   function automatic fenp_state_type close_tok(input fenp_state_type st);
      fenp_state_type r;
      r = st;
      if (st.in_token) begin
         if (st.field_number == FIELD_PASSANT) begin
            if (st.token_length == 3'd2 && st.tok_first >= CHAR_A && st.tok_first <= CHAR_H &&
                st.tok_second >= CHAR_ONE && st.tok_second <= CHAR_EIGHT) begin
               r.passant_flag  = 1'b1;
               r.passant_index = {st.tok_second[2:0] - 3'd1, st.tok_first[2:0] - 3'd1};
            end else begin
               r.passant_flag  = 1'b0;
               r.passant_index = '0;
            end
         end else if (st.field_number == FIELD_HALFMOVE && st.bm_match == BM_MATCH) begin
            r.halfmove_seen  = 1'b0;
            r.halfmove_accum = '0;
         end
         r.in_token = 1'b0;
         if (st.field_number < FIELD_LAST) begin
            r.field_number = st.field_number + 3'd1;
         end
      end
      return r;
   endfunction

   fenp_state_type s;
   fenp_state_type closed;
   logic       blank;
   logic       digit;
   logic       upper;
   logic [7:0] lower;
   logic       piece_ok;
   logic [2:0] kind;
   logic [4:0] file_sum;
   logic [13:0] times_ten;

   assign closed = close_tok(state);
   assign blank  = character == CHAR_SPACE || (character >= CHAR_TAB && character <= CHAR_CR);
   assign digit  = character >= CHAR_ZERO && character <= CHAR_NINE;
   assign upper  = character >= CHAR_UPPER_A && character <= CHAR_UPPER_Z;
   assign lower  = upper ? (character | 8'h20) : character;

   always_comb begin
      piece_ok = 1'b1;
      case (lower)
         CHAR_P:  kind = PIECE_PAWN;
         CHAR_N:  kind = PIECE_KNIGHT;
         CHAR_B:  kind = PIECE_BISHOP;
         CHAR_R:  kind = PIECE_ROOK;
         CHAR_Q:  kind = PIECE_QUEEN;
         CHAR_K:  kind = PIECE_KING;
         default: begin
            kind = PIECE_PAWN;
            piece_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      s = state;
      emit = 1'b0;
      result = '0;
      file_sum = '0;
      times_ten = '0;
      if (command) begin
         emit = 1'b1;
         result.record_kind    = RECORD_SUMMARY;
         result.black_to_move  = closed.side_flag;
         result.castle_rights  = closed.castle_flags;
         result.passant_valid  = closed.passant_flag;
         result.passant_square = closed.passant_flag ? closed.passant_index : 6'd0;
         result.halfmove_valid = closed.halfmove_seen;
         result.halfmove_count = closed.halfmove_seen ? closed.halfmove_accum : '0;
         s = STATE_RESET;
      end else if (blank) begin
         s = closed;
      end else begin
         if (!s.in_token) begin
            s.in_token       = 1'b1;
            s.token_length   = '0;
            s.bm_match       = BM_IDLE;
            s.tok_first      = '0;
            s.tok_second     = '0;
            s.digits_running = 1'b0;
            if (s.field_number == FIELD_CASTLE) begin
               s.castle_flags = '0;
            end
         end
         if (s.token_length == 3'd0) begin
            s.tok_first = character;
            s.bm_match  = (character == CHAR_B) ? BM_B : BM_NONE;
         end else if (s.token_length == 3'd1) begin
            s.tok_second = character;
            s.bm_match   = (s.bm_match == BM_B && character == CHAR_M) ? BM_MATCH : BM_NONE;
         end else begin
            s.bm_match = BM_NONE;
         end

         case (s.field_number)
            FIELD_PLACEMENT: begin
               if (character == CHAR_SLASH) begin
                  if (s.rank_row < BOARD_EDGE) begin
                     s.rank_row = s.rank_row + 4'd1;
                  end
                  s.file_column = '0;
               end else if (digit) begin
                  file_sum = {1'b0, s.file_column} + {1'b0, character[3:0]};
                  s.file_column = (file_sum > 5'd8) ? BOARD_EDGE : file_sum[3:0];
               end else if (piece_ok) begin
                  if (s.file_column < BOARD_EDGE && s.rank_row < BOARD_EDGE) begin
                     emit = 1'b1;
                     result.record_kind = RECORD_PIECE;
                     result.square      = {~s.rank_row[2:0], s.file_column[2:0]};
                     result.piece_color = ~upper;
                     result.piece_kind  = kind;
                  end
                  if (s.file_column < BOARD_EDGE) begin
                     s.file_column = s.file_column + 4'd1;
                  end
               end
            end
            FIELD_SIDE: begin
               if (s.token_length == 3'd0) begin
                  if (character == CHAR_W) begin
                     s.side_flag = 1'b0;
                  end else if (character == CHAR_B) begin
                     s.side_flag = 1'b1;
                  end
               end
            end
            FIELD_CASTLE: begin
               if (character == CHAR_UPPER_K) begin
                  s.castle_flags[0] = 1'b1;
               end else if (character == CHAR_UPPER_Q) begin
                  s.castle_flags[1] = 1'b1;
               end else if (character == CHAR_K) begin
                  s.castle_flags[2] = 1'b1;
               end else if (character == CHAR_Q) begin
                  s.castle_flags[3] = 1'b1;
               end
            end
            FIELD_HALFMOVE: begin
               if (digit) begin
                  if (s.token_length == 3'd0) begin
                     s.halfmove_seen  = 1'b1;
                     s.halfmove_accum = '0;
                     s.digits_running = 1'b1;
                  end
                  if (s.digits_running) begin
                     times_ten = {1'b0, s.halfmove_accum, 3'b000}
                               + {3'b000, s.halfmove_accum, 1'b0}
                               + {10'd0, character[3:0]};
                     s.halfmove_accum = (times_ten > {4'd0, HALFMOVE_MAX}) ?
                                        HALFMOVE_MAX : times_ten[HALFMOVE_WIDTH-1:0];
                  end
               end else begin
                  s.digits_running = 1'b0;
               end
            end
            default: begin
            end
         endcase

         if (s.token_length < TOKEN_LENGTH_MAX) begin
            s.token_length = s.token_length + 3'd1;
         end
      end
      state_next = s;
   end

endmodule

### sim/fen_position_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the chess position string parser.
module fen_position_parser_tb;
   import fenp_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned TARGET_REQUESTS = 1050;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   class position_scoreboard;
      fenp_result_type pending_records[$];
      int unsigned mismatch_count;
      logic [2:0] field_no;
      logic       in_token;
      logic [3:0] rank_pos;
      logic [3:0] file_pos;
      logic       black_side;
      logic [3:0] castle_bits;
      logic       ep_valid;
      logic [5:0] ep_square;
      logic [2:0] token_len;
      logic [1:0] bm_state;
      logic [9:0] half_count;
      logic       half_seen;
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       digits_on;

      function new();
         mismatch_count = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         field_no = FIELD_PLACEMENT;
         in_token = 0;
         rank_pos = 0;
         file_pos = 0;
         black_side = 0;
         castle_bits = 0;
         ep_valid = 0;
         ep_square = 0;
         token_len = 0;
         bm_state = BM_IDLE;
         half_count = 0;
         half_seen = 0;
         first_char = 0;
         second_char = 0;
         digits_on = 0;
      endfunction

      function void close_token();
         int unsigned row;
         int unsigned col;
         if (!in_token)
            return;
         if (field_no == FIELD_PASSANT) begin
            if (token_len == 3'd2 && first_char >= CHAR_A && first_char <= CHAR_H &&
                second_char >= CHAR_ONE && second_char <= CHAR_EIGHT) begin
               row = 32'(second_char - CHAR_ONE);
               col = 32'(first_char - CHAR_A);
               ep_valid = 1;
               ep_square = 6'(row * 8 + col);
            end else begin
               ep_valid = 0;
               ep_square = 0;
            end
         end else if (field_no == FIELD_HALFMOVE && bm_state == BM_MATCH) begin
            half_seen = 0;
            half_count = 0;
         end
         in_token = 0;
         if (field_no < FIELD_LAST)
            field_no++;
      endfunction

      function void take_character(logic [7:0] c);
         logic [7:0] lower;
         logic [2:0] kind;
         logic hit;
         int unsigned next_val;
         fenp_result_type rec;
         if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            close_token();
            return;
         end
         if (!in_token) begin
            in_token = 1;
            token_len = 0;
            bm_state = BM_IDLE;
            first_char = 0;
            second_char = 0;
            digits_on = 0;
            if (field_no == FIELD_CASTLE)
               castle_bits = 0;
         end
         if (token_len == 0) begin
            first_char = c;
            bm_state = (c == CHAR_B) ? BM_B : BM_NONE;
         end else if (token_len == 1) begin
            second_char = c;
            bm_state = (bm_state == BM_B && c == CHAR_M) ? BM_MATCH : BM_NONE;
         end else begin
            bm_state = BM_NONE;
         end

         case (field_no)
            FIELD_PLACEMENT: begin
               if (c == CHAR_SLASH) begin
                  if (rank_pos < BOARD_EDGE)
                     rank_pos++;
                  file_pos = 0;
               end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  next_val = 32'(file_pos) + 32'(c - CHAR_ZERO);
                  file_pos = (next_val > BOARD_EDGE) ? BOARD_EDGE : 4'(next_val);
               end else begin
                  lower = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + 8'd32 : c;
                  hit = 1;
                  kind = PIECE_PAWN;
                  case (lower)
                     CHAR_P: kind = PIECE_PAWN;
                     CHAR_N: kind = PIECE_KNIGHT;
                     CHAR_B: kind = PIECE_BISHOP;
                     CHAR_R: kind = PIECE_ROOK;
                     CHAR_Q: kind = PIECE_QUEEN;
                     CHAR_K: kind = PIECE_KING;
                     default: hit = 0;
                  endcase
                  if (hit) begin
                     if (file_pos < BOARD_EDGE && rank_pos < BOARD_EDGE) begin
                        rec = '0;
                        rec.record_kind = RECORD_PIECE;
                        rec.square = {~rank_pos[2:0], file_pos[2:0]};
                        rec.piece_color = (c == lower);
                        rec.piece_kind = kind;
                        pending_records.push_back(rec);
                     end
                     if (file_pos < BOARD_EDGE)
                        file_pos++;
                  end
               end
            end
            FIELD_SIDE: begin
               if (token_len == 0) begin
                  if (c == CHAR_W)
                     black_side = 0;
                  else if (c == CHAR_B)
                     black_side = 1;
               end
            end
            FIELD_CASTLE: begin
               if (c == CHAR_UPPER_K)
                  castle_bits[0] = 1;
               else if (c == CHAR_UPPER_Q)
                  castle_bits[1] = 1;
               else if (c == CHAR_K)
                  castle_bits[2] = 1;
               else if (c == CHAR_Q)
                  castle_bits[3] = 1;
            end
            FIELD_HALFMOVE: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  if (token_len == 0) begin
                     half_seen = 1;
                     half_count = 0;
                     digits_on = 1;
                  end
                  if (digits_on) begin
                     next_val = 32'(half_count) * 10 + 32'(c - CHAR_ZERO);
                     half_count = (next_val > HALFMOVE_MAX) ? HALFMOVE_MAX : 10'(next_val);
                  end
               end else begin
                  digits_on = 0;
               end
            end
            default: ;
         endcase
         if (token_len < TOKEN_LENGTH_MAX)
            token_len++;
      endfunction

      function void note_request(logic cmd, logic [7:0] c);
         fenp_result_type rec;
         if (!cmd) begin
            take_character(c);
            return;
         end
         close_token();
         rec = '0;
         rec.record_kind = RECORD_SUMMARY;
         rec.black_to_move = black_side;
         rec.castle_rights = castle_bits;
         rec.passant_valid = ep_valid;
         rec.passant_square = ep_valid ? ep_square : 6'd0;
         rec.halfmove_valid = half_seen;
         rec.halfmove_count = half_seen ? half_count : 10'd0;
         pending_records.push_back(rec);
         clear_parser();
      endfunction

      function string describe(fenp_result_type r);
         return $sformatf({"kind=%0d sq=%0d color=%0d piece=%0d black=%0d castle=%h",
                           " ep=%0d/%0d half=%0d/%0d"},
                          r.record_kind, r.square, r.piece_color, r.piece_kind, r.black_to_move,
                          r.castle_rights, r.passant_valid, r.passant_square, r.halfmove_valid,
                          r.halfmove_count);
      endfunction

      function void check_record(fenp_result_type got);
         fenp_result_type want;
         if (pending_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected record: %s", describe(got));
            return;
         end
         want = pending_records.pop_front();
         if (got.record_kind !== want.record_kind || got.square !== want.square ||
             got.piece_color !== want.piece_color || got.piece_kind !== want.piece_kind ||
             got.black_to_move !== want.black_to_move ||
             got.castle_rights !== want.castle_rights ||
             got.passant_valid !== want.passant_valid ||
             got.passant_square !== want.passant_square ||
             got.halfmove_valid !== want.halfmove_valid ||
             got.halfmove_count !== want.halfmove_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("record mismatch at %0t", $realtime);
               $display("  expected: %s", describe(want));
               $display("  actual:   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic idle_on;
   int unsigned request_count;
   position_scoreboard parser_check;

   fenp_req_if req_ch ();
   fenp_rsp_if rsp_ch ();

   fen_position_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin : monitor
      fenp_result_type got;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.record_kind = rsp_ch.record_kind;
            got.square = rsp_ch.square;
            got.piece_color = rsp_ch.piece_color;
            got.piece_kind = rsp_ch.piece_kind;
            got.black_to_move = rsp_ch.black_to_move;
            got.castle_rights = rsp_ch.castle_rights;
            got.passant_valid = rsp_ch.passant_valid;
            got.passant_square = rsp_ch.passant_square;
            got.halfmove_valid = rsp_ch.halfmove_valid;
            got.halfmove_count = rsp_ch.halfmove_count;
            parser_check.check_record(got);
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            parser_check.note_request(req_ch.command, req_ch.character);
      end
   end

   initial begin : watchdog
      int unsigned stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stalled = 0;
         else
            stalled++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic send_request(input logic cmd, input logic [7:0] c);
      while (idle_on && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         req_ch.command <= 1'($urandom_range(1));
         req_ch.character <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.character <= c;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      request_count++;
   endtask

   task automatic send_char(input logic [7:0] c);
      send_request(1'b0, c);
   endtask

   task automatic send_end();
      send_request(1'b1, 8'($urandom_range(255)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(3) == 0 ? $urandom_range(2, 3) : 1) begin
         if ($urandom_range(9) < 7)
            send_char(CHAR_SPACE);
         else
            send_char(8'(CHAR_TAB + $urandom_range(4)));
      end
   endtask

   function automatic logic [7:0] random_piece();
      string letters = "PNBRQKpnbrqk";
      return letters[$urandom_range(11)];
   endfunction

   // hold off new requests until every pending record is out
   task automatic drain_records();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (parser_check.pending_records.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 16))
         send_char(8'($urandom_range(255)));
      send_end();
   endtask

   task automatic send_position();
      string rights = "KQkq";
      int unsigned fields;
      int unsigned ranks;
      int unsigned col;
      int unsigned step;
      bit any;
      fields = ($urandom_range(9) < 7) ? 6 : $urandom_range(5);
      if ($urandom_range(7) == 0)
         send_blanks();

      ranks = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : 8;
      for (int r = 0; r < ranks; r++) begin
         col = 0;
         while (col < 8) begin
            if ($urandom_range(2) == 0) begin
               step = $urandom_range(1, 8 - col);
               send_char(8'(CHAR_ZERO + step));
               col += step;
            end else begin
               send_char(random_piece());
               col++;
            end
         end
         if ($urandom_range(11) == 0) begin
            case ($urandom_range(3))
               0: send_char(CHAR_ZERO);
               1: send_char(CHAR_NINE);
               2: send_char(random_piece());
               default: send_char(8'($urandom_range(255)));
            endcase
         end
         if (r + 1 < ranks)
            send_char(CHAR_SLASH);
      end

      if (fields >= 1) begin
         send_blanks();
         if ($urandom_range(7) == 0)
            send_char(8'($urandom_range(255)));
         else
            send_char($urandom_range(1) ? CHAR_W : CHAR_B);
         if ($urandom_range(9) == 0)
            send_char(CHAR_W);
      end

      if (fields >= 2) begin
         send_blanks();
         any = 0;
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(1)) begin
               send_char(rights[i]);
               any = 1;
            end
         end
         if (!any)
            send_char(CHAR_DASH);
         if ($urandom_range(9) == 0)
            send_char(random_piece());
      end

      if (fields >= 3) begin
         send_blanks();
         case ($urandom_range(7))
            0, 1, 2: send_char(CHAR_DASH);
            3: begin
               send_char(8'(CHAR_A + $urandom_range(9)));
               send_char(8'(CHAR_ZERO + $urandom_range(9)));
               if ($urandom_range(1))
                  send_char(8'(CHAR_ONE + $urandom_range(7)));
            end
            default: begin
               send_char(8'(CHAR_A + $urandom_range(7)));
               send_char(8'(CHAR_ONE + $urandom_range(7)));
            end
         endcase
      end

      if (fields >= 4) begin
         send_blanks();
         case ($urandom_range(15))
            0, 1: send_text("bm");
            2: send_text("bmx");
            3: send_text("b");
            4: send_text("x5");
            5: send_text("12a3");
            6: send_text("1023");
            7: send_text($sformatf("%0d", $urandom_range(1000, 99999)));
            default: send_text($sformatf("%0d", $urandom_range(99)));
         endcase
      end

      if (fields >= 5) begin
         send_blanks();
         send_text($sformatf("%0d", $urandom_range(1, 200)));
      end

      if (fields >= 6) begin
         send_blanks();
         send_text("bm");
         send_blanks();
         send_text("Qxe7+");
      end

      if ($urandom_range(1))
         send_blanks();
      send_end();
   endtask

   initial begin
      parser_check = new();
      request_count = 0;
      idle_on = 1'b1;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= 1'b0;
      req_ch.character <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_text("\tKz9q/ b Kq h8 1100");
      send_request(1'b1, 8'hFF);
      send_text("rnbqkNBRQP w - a1 bm");
      send_request(1'b1, 8'h00);
      drain_records();

      for (int unsigned s = 0; request_count < TARGET_REQUESTS; s++) begin
         idle_on = !(s >= 6 && s < 12);
         if (s == 14)
            drain_records();
         if ($urandom_range(9) == 0)
            send_noise();
         else
            send_position();
      end

      idle_on = 1'b1;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (parser_check.pending_records.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (parser_check.mismatch_count == 0 && parser_check.pending_records.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
